FILE: rtl/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared sizes and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int DEPTH       = 128;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CHILD_W     = ADDR_W + 2;
    localparam int COUNT_OUT_W = 8;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

endpackage

FILE: rtl/hpq_ram.sv
// ----------------------------------------------------------------------------
// hpq_ram
// Heap store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hpq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd0_addr,
    input  logic [ADDR_W-1:0] rd1_addr,
    output logic [DATA_W-1:0] rd0_data,
    output logic [DATA_W-1:0] rd1_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

FILE: rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit words held in a two-read-port store.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  command  | start / busy         | opcode, value
//  result   | done (1-cycle pulse) | status, removed_value, count_after
//
//  An insert sifts up in S_UP_CMP, one level per store read round, and S_FIN
//  writes the word; a remove reads the root and the last word in S_DN_ROOT,
//  sifts down in S_DN_CMP, one level per round, and S_FIN writes the word.
//  At most log2(DEPTH) levels move. Full insert and empty remove skip these.
//  busy is low in the done cycle. Reset empties the heap; the store is kept.
//  The result is not held: the receiver takes it in the done cycle.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
    import hpq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    opcode,
    input  logic signed [31:0]      value,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [31:0]      removed_value,
    output logic [COUNT_OUT_W-1:0]  count_after
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_UP_CMP  = 5'b00010,
        S_DN_ROOT = 5'b00100,
        S_DN_CMP  = 5'b01000,
        S_FIN     = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0]  v_reg, v_next;
    logic signed [DATA_W-1:0]  removed_reg, removed_next;
    status_t                   status_reg, status_next;
    logic                      done_reg, done_next;

    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [DATA_W-1:0]         wr_data;
    logic [ADDR_W-1:0]         rd0_addr, rd1_addr;
    logic [DATA_W-1:0]         rd0_data, rd1_data;

    logic [ADDR_W-1:0]         up_parent;
    logic [CHILD_W-1:0]        l_idx, r_idx, best_idx, rd_left;
    logic                      l_ok, r_ok, take_r, take_l;
    logic signed [DATA_W-1:0]  best_val;

    function automatic logic [CHILD_W-1:0] left_of(input logic [ADDR_W-1:0] p);
        return {1'b0, p, 1'b1};
    endfunction

    hpq_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd0_addr (rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data)
    );

    always_comb
    begin
        up_parent = (pos_reg - ADDR_W'(1)) >> 1;
        l_idx     = left_of(pos_reg);
        r_idx     = l_idx + CHILD_W'(1);
        l_ok      = l_idx < CHILD_W'(count_reg);
        r_ok      = r_idx < CHILD_W'(count_reg);
        take_r    = r_ok && ($signed(rd1_data) > v_reg);
        best_val  = take_r ? $signed(rd1_data) : v_reg;
        take_l    = l_ok && ($signed(rd0_data) > best_val);
        best_idx  = take_l ? l_idx : r_idx;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        v_next       = v_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        done_next    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = v_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    removed_next = '0;
                    status_next  = ST_DONE;
                    if (opcode == OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            pos_next   = ADDR_W'(count_reg);
                            v_next     = value;
                            count_next = count_reg + CNT_W'(1);
                            state_next = (count_reg == '0) ? S_FIN : S_UP_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_DN_ROOT;
                        end
                    end
                end
            end
            S_UP_CMP:
            begin
                if (v_reg > $signed(rd0_data))
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd0_data;
                    pos_next   = up_parent;
                    state_next = (up_parent == '0) ? S_FIN : S_UP_CMP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_ROOT:
            begin
                removed_next = $signed(rd0_data);
                v_next       = $signed(rd1_data);
                pos_next     = '0;
                state_next   = (left_of('0) < CHILD_W'(count_reg)) ? S_DN_CMP : S_FIN;
            end
            S_DN_CMP:
            begin
                if (take_l || take_r)
                begin
                    wr_en      = 1'b1;
                    wr_data    = take_l ? rd0_data : rd1_data;
                    pos_next   = best_idx[ADDR_W-1:0];
                    state_next = (left_of(best_idx[ADDR_W-1:0]) < CHILD_W'(count_reg))
                                 ? S_DN_CMP : S_FIN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                wr_en      = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_left = left_of(pos_next);
        if (state_reg == S_IDLE)
        begin
            rd0_addr = (opcode == OP_INSERT)
                       ? ADDR_W'((count_reg - CNT_W'(1)) >> 1) : '0;
            rd1_addr = ADDR_W'(count_reg - CNT_W'(1));
        end
        else if (state_next == S_UP_CMP)
        begin
            rd0_addr = (pos_next - ADDR_W'(1)) >> 1;
            rd1_addr = pos_next;
        end
        else
        begin
            rd0_addr = rd_left[ADDR_W-1:0];
            rd1_addr = rd_left[ADDR_W-1:0] + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        v_reg       <= v_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign count_after   = COUNT_OUT_W'(count_reg);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result word outside idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("heap count beyond depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_INSERT) && (count_reg == CNT_W'(DEPTH)))
        |=> (done_reg && (status_reg == ST_FULL) && $stable(count_reg)))
        else $error("full insert not dropped");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_DONE)) |-> (removed_reg == '0))
        else $error("failed word carries a value");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_UP_CMP) || (state_reg == S_DN_CMP)
                   || (state_reg == S_FIN)))
        else $error("store write outside sift");

endmodule
